### hw/rtl/mwss_pkg.sv
// ----------------------------------------------------------------------------
// mwss_pkg
// Shared widths, types and codes for the moving window sum and squares block.
// ----------------------------------------------------------------------------
package mwss_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = 24;
	localparam int SQ_W        = 39;
	localparam int SQ_OUT_W    = 38;
	localparam int WL_W        = 8;
	localparam int SENSOR_W    = 2;
	localparam int AXIS_W      = 2;
	localparam int QUEUE_DEPTH = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [SQ_W-1:0]            sq_t;
	typedef logic [SQ_OUT_W-1:0]        sq_out_t;
	typedef logic [WL_W-1:0]            wl_t;
	typedef logic [SENSOR_W-1:0]        sensor_t;
	typedef logic [AXIS_W-1:0]          axis_t;

	typedef enum logic [1:0] {
		TOGGLE_NONE  = 2'd0,
		TOGGLE_AMBER = 2'd1,
		TOGGLE_BLUE  = 2'd2
	} toggle_t;

	localparam wl_t     WL_RESET     = 8'd100;
	localparam sensor_t AMBER_SENSOR = 2'd1;
	localparam sensor_t BLUE_SENSOR  = 2'd2;

endpackage

### hw/rtl/mwss_ram.sv
// ----------------------------------------------------------------------------
// mwss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mwss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2304
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/mwss_queue.sv
// ----------------------------------------------------------------------------
// mwss_queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mwss_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/mwss_front.sv
// ----------------------------------------------------------------------------
// mwss_front
// Takes input beats, drops unknown sensors, assigns the ring slot and the wrap
// flag per sensor, and holds the window length register.
// ----------------------------------------------------------------------------
module mwss_front #(
	parameter int WINDOW_MAX = 256,
	parameter int AXES       = 3,
	parameter int SENSORS    = 3,
	parameter int ENTRY_W    = 60
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 window_length_we,
	input  mwss_pkg::wl_t        window_length,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mwss_pkg::sensor_t    sensor_select,
	input  mwss_pkg::sample_t    sample_x,
	input  mwss_pkg::sample_t    sample_y,
	input  mwss_pkg::sample_t    sample_z,
	input  logic                 q_full,
	output logic                 q_push,
	output logic [ENTRY_W-1:0]   q_entry,
	output logic                 clear
);

	import mwss_pkg::*;

	localparam int PW      = $clog2(WINDOW_MAX);
	localparam int SW      = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int SMP_LSB = PW + 4;
	localparam logic [WL_W:0] WL_LIMIT = (WL_W + 1)'(WINDOW_MAX);

	logic [PW-1:0] pos_q  [SENSORS];
	logic          full_q [SENSORS];
	wl_t           wl_q;

	sample_t       smp [3];
	logic          known;
	logic [SW-1:0] sel;
	logic [PW-1:0] pos;
	logic [WL_W:0] next;
	logic          wrap;
	logic          take;

	assign smp   = '{sample_x, sample_y, sample_z};
	assign known = (int'(sensor_select) < SENSORS);
	assign sel   = SW'(sensor_select);
	assign pos   = pos_q[sel];
	assign next  = (WL_W + 1)'(pos) + 1'b1;
	assign wrap  = (next >= {1'b0, wl_q});

	assign in_stall = q_full;
	assign take     = in_valid && !q_full && known;
	assign q_push   = take;

	assign clear = window_length_we && (window_length != '0)
		&& ({1'b0, window_length} < WL_LIMIT) && (window_length != wl_q);

	always_comb begin
		q_entry = '0;
		q_entry[SENSOR_W-1:0] = sensor_select;
		q_entry[PW+1:2]       = pos;
		q_entry[PW+2]         = wrap;
		q_entry[PW+3]         = full_q[sel];
		for (int a = 0; a < AXES; a++) begin
			q_entry[SMP_LSB + a*SAMPLE_W +: SAMPLE_W] = smp[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= WL_RESET;
			pos_q  <= '{default: '0};
			full_q <= '{default: 1'b0};
		end else if (clear) begin
			wl_q   <= window_length;
			pos_q  <= '{default: '0};
			full_q <= '{default: 1'b0};
		end else if (take) begin
			pos_q[sel] <= wrap ? '0 : next[PW-1:0];
			if (wrap) begin
				full_q[sel] <= 1'b1;
			end
		end
	end

endmodule

### hw/rtl/mwss_back.sv
// ----------------------------------------------------------------------------
// mwss_back
// Works through one axis per cycle while the output is not stalled: reads the old sample
// from the ring, squares both samples, updates the window and slice totals and registers
// the result beat.
// ----------------------------------------------------------------------------
module mwss_back #(
	parameter int WINDOW_MAX = 256,
	parameter int AXES       = 3,
	parameter int SENSORS    = 3,
	parameter int ENTRY_W    = 60
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 q_valid,
	input  logic [ENTRY_W-1:0]   q_entry,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mwss_pkg::axis_t      axis,
	output mwss_pkg::sum_t       window_total,
	output mwss_pkg::sq_out_t    window_square_total,
	output logic                 slice_done,
	output mwss_pkg::sum_t       slice_total,
	output mwss_pkg::sq_out_t    slice_square_total,
	output mwss_pkg::toggle_t    indicator_toggle,
	output logic                 last
);

	import mwss_pkg::*;

	localparam int PW      = $clog2(WINDOW_MAX);
	localparam int SMP_LSB = PW + 4;
	localparam int PAIRS   = SENSORS * AXES;
	localparam int PRW     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int DEPTH   = PAIRS * WINDOW_MAX;
	localparam int AW      = $clog2(DEPTH);
	localparam int PROD_W  = 2 * SAMPLE_W;
	localparam axis_t LAST_AXIS = AXIS_W'(AXES - 1);

	logic     advance;
	logic     issue;
	axis_t    ax_q;
	sensor_t  h_sensor;
	logic [PW-1:0] h_pos;
	logic     h_wrap;
	logic     h_ovalid;
	sample_t  h_sample;
	logic [PRW-1:0] h_pair;
	logic [AW-1:0]  h_addr;

	logic           v_s1;
	logic [PRW-1:0] pair_s1;
	logic [AW-1:0]  addr_s1;
	sample_t        smp_s1;
	logic           wrap_s1;
	logic           ovalid_s1;
	sensor_t        sensor_s1;
	axis_t          ax_s1;
	sample_t        rd_s1;
	sample_t        old_s1;
	logic signed [PROD_W-1:0] old_sq_w;
	logic signed [PROD_W-1:0] new_sq_w;

	logic           v_s2;
	logic [PRW-1:0] pair_s2;
	sample_t        smp_s2;
	sample_t        old_s2;
	logic [PROD_W-1:0] old_sq_s2;
	logic [PROD_W-1:0] new_sq_s2;
	logic           wrap_s2;
	sensor_t        sensor_s2;
	axis_t          ax_s2;

	sum_t win_sum_q  [PAIRS];
	sq_t  win_sq_q   [PAIRS];
	sum_t slc_sum_q  [PAIRS];
	sq_t  slc_sq_q   [PAIRS];
	sum_t comp_sum_q [PAIRS];
	sq_t  comp_sq_q  [PAIRS];

	sum_t    win_sum_n;
	sq_t     win_sq_n;
	sum_t    slc_sum_n;
	sq_t     slc_sq_n;
	sum_t    done_sum;
	sq_t     done_sq;
	toggle_t toggle_n;

	logic    out_valid_q;
	axis_t   axis_q;
	sum_t    wtot_q;
	sq_t     wsq_q;
	logic    done_q;
	sum_t    stot_q;
	sq_t     ssq_q;
	toggle_t tog_q;
	logic    last_q;

	assign advance = !(out_valid_q && out_stall);
	assign issue   = advance && q_valid;
	assign q_pop   = issue && (ax_q == LAST_AXIS);

	assign h_sensor = q_entry[SENSOR_W-1:0];
	assign h_pos    = q_entry[PW+1:2];
	assign h_wrap   = q_entry[PW+2];
	assign h_ovalid = q_entry[PW+3];
	assign h_sample = q_entry[SMP_LSB + int'(ax_q)*SAMPLE_W +: SAMPLE_W];
	assign h_pair   = PRW'(int'(h_sensor) * AXES + int'(ax_q));
	assign h_addr   = AW'(int'(h_pair) * WINDOW_MAX + int'(h_pos));

	mwss_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (v_s1 && advance),
		.waddr (addr_s1),
		.wdata (smp_s1),
		.re    (issue),
		.raddr (h_addr),
		.rdata (rd_s1)
	);

	assign old_s1   = ovalid_s1 ? rd_s1 : '0;
	assign old_sq_w = old_s1 * old_s1;
	assign new_sq_w = smp_s1 * smp_s1;

	always_comb begin
		win_sum_n = win_sum_q[pair_s2] - SUM_W'(old_s2) + SUM_W'(smp_s2);
		win_sq_n  = win_sq_q[pair_s2] - SQ_W'(old_sq_s2) + SQ_W'(new_sq_s2);
		slc_sum_n = slc_sum_q[pair_s2] + SUM_W'(smp_s2);
		slc_sq_n  = slc_sq_q[pair_s2] + SQ_W'(new_sq_s2);
		done_sum  = wrap_s2 ? slc_sum_n : comp_sum_q[pair_s2];
		done_sq   = wrap_s2 ? slc_sq_n : comp_sq_q[pair_s2];
		toggle_n  = TOGGLE_NONE;
		if (wrap_s2 && (slc_sum_n == '0)) begin
			unique case (sensor_s2)
				AMBER_SENSOR: toggle_n = TOGGLE_AMBER;
				BLUE_SENSOR:  toggle_n = TOGGLE_BLUE;
				default:      toggle_n = TOGGLE_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
			if (issue) begin
				ax_q <= q_pop ? '0 : ax_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pair_s1   <= h_pair;
			addr_s1   <= h_addr;
			smp_s1    <= h_sample;
			wrap_s1   <= h_wrap;
			ovalid_s1 <= h_ovalid;
			sensor_s1 <= h_sensor;
			ax_s1     <= ax_q;
		end
		if (advance && v_s1) begin
			pair_s2   <= pair_s1;
			smp_s2    <= smp_s1;
			old_s2    <= old_s1;
			old_sq_s2 <= old_sq_w;
			new_sq_s2 <= new_sq_w;
			wrap_s2   <= wrap_s1;
			sensor_s2 <= sensor_s1;
			ax_s2     <= ax_s1;
		end
		if (advance && v_s2) begin
			axis_q <= ax_s2;
			wtot_q <= win_sum_n;
			wsq_q  <= win_sq_n;
			done_q <= wrap_s2;
			stot_q <= done_sum;
			ssq_q  <= done_sq;
			tog_q  <= toggle_n;
			last_q <= (ax_s2 == LAST_AXIS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_sum_q  <= '{default: '0};
			win_sq_q   <= '{default: '0};
			slc_sum_q  <= '{default: '0};
			slc_sq_q   <= '{default: '0};
			comp_sum_q <= '{default: '0};
			comp_sq_q  <= '{default: '0};
		end else if (clear) begin
			win_sum_q  <= '{default: '0};
			win_sq_q   <= '{default: '0};
			slc_sum_q  <= '{default: '0};
			slc_sq_q   <= '{default: '0};
			comp_sum_q <= '{default: '0};
			comp_sq_q  <= '{default: '0};
		end else if (advance && v_s2) begin
			win_sum_q[pair_s2] <= win_sum_n;
			win_sq_q[pair_s2]  <= win_sq_n;
			slc_sum_q[pair_s2] <= wrap_s2 ? '0 : slc_sum_n;
			slc_sq_q[pair_s2]  <= wrap_s2 ? '0 : slc_sq_n;
			if (wrap_s2) begin
				comp_sum_q[pair_s2] <= slc_sum_n;
				comp_sq_q[pair_s2]  <= slc_sq_n;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign axis                = axis_q;
	assign window_total        = wtot_q;
	assign window_square_total = wsq_q[SQ_OUT_W-1:0];
	assign slice_done          = done_q;
	assign slice_total         = stot_q;
	assign slice_square_total  = ssq_q[SQ_OUT_W-1:0];
	assign indicator_toggle    = tog_q;
	assign last                = last_q;

endmodule

### hw/rtl/moving_window_sum_and_squares.sv
// The X result of a beat passes through the queue and the s1, s2 and output registers; Y and Z
// follow directly behind it when the output is not stalled.
// The back end handles one axis per cycle through the single ring read port while the output
// is not stalled and pops a beat after its last axis; a four-entry queue absorbs input bursts.
// Reset clears all sums, ring positions and the window length (to 100). The ring memory is
// not swept: a per-sensor fill flag makes unwritten slots read as zero until the ring wraps.
// ----------------------------------------------------------------------------
// moving_window_sum_and_squares
// Moving window sum and sum of squares per sensor and axis, with slice totals.
// ----------------------------------------------------------------------------
module moving_window_sum_and_squares #(
	parameter int WINDOW_MAX = 256,
	parameter int AXES       = 3,
	parameter int SENSORS    = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 window_length_we,
	input  mwss_pkg::wl_t        window_length,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mwss_pkg::sensor_t    sensor_select,
	input  mwss_pkg::sample_t    sample_x,
	input  mwss_pkg::sample_t    sample_y,
	input  mwss_pkg::sample_t    sample_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mwss_pkg::axis_t      axis,
	output mwss_pkg::sum_t       window_total,
	output mwss_pkg::sq_out_t    window_square_total,
	output logic                 slice_done,
	output mwss_pkg::sum_t       slice_total,
	output mwss_pkg::sq_out_t    slice_square_total,
	output mwss_pkg::toggle_t    indicator_toggle,
	output logic                 last
);

	import mwss_pkg::*;

	localparam int ENTRY_W = AXES * SAMPLE_W + $clog2(WINDOW_MAX) + 4;

	logic               q_full;
	logic               q_push;
	logic [ENTRY_W-1:0] q_wdata;
	logic               q_pop;
	logic               q_valid;
	logic [ENTRY_W-1:0] q_rdata;
	logic               clear;

	mwss_front #(
		.WINDOW_MAX (WINDOW_MAX),
		.AXES       (AXES),
		.SENSORS    (SENSORS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_length_we (window_length_we),
		.window_length    (window_length),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sensor_select    (sensor_select),
		.sample_x         (sample_x),
		.sample_y         (sample_y),
		.sample_z         (sample_z),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_entry          (q_wdata),
		.clear            (clear)
	);

	mwss_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	mwss_back #(
		.WINDOW_MAX (WINDOW_MAX),
		.AXES       (AXES),
		.SENSORS    (SENSORS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.clear               (clear),
		.q_valid             (q_valid),
		.q_entry             (q_rdata),
		.q_pop               (q_pop),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.axis                (axis),
		.window_total        (window_total),
		.window_square_total (window_square_total),
		.slice_done          (slice_done),
		.slice_total         (slice_total),
		.slice_square_total  (slice_square_total),
		.indicator_toggle    (indicator_toggle),
		.last                (last)
	);

endmodule

### hw/rtl/mwss_checker.sv
// ----------------------------------------------------------------------------
// mwss_checker
// Port-level checks on the result channel of the moving window block.
// ----------------------------------------------------------------------------
module mwss_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input mwss_pkg::axis_t      axis,
	input mwss_pkg::sum_t       window_total,
	input logic                 slice_done,
	input mwss_pkg::sum_t       slice_total,
	input mwss_pkg::toggle_t    indicator_toggle,
	input logic                 last
);

	import mwss_pkg::*;

	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(axis) && $stable(window_total))
		else $error("stalled result beat changed");

	// The axis results of one sample come back to back in rising axis order.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && (axis == 2'($past(axis) + 2'd1)))
		else $error("axis results of one sample are not contiguous");

	// All axis results of one sample agree on the slice wrap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> slice_done == $past(slice_done))
		else $error("slice wrap differs between axes of one sample");

	// A toggle only comes with a completed slice whose total is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (indicator_toggle != TOGGLE_NONE) |-> slice_done && (slice_total == '0))
		else $error("indicator toggle without a zero completed slice");

endmodule

bind moving_window_sum_and_squares mwss_checker u_mwss_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.axis             (axis),
	.window_total     (window_total),
	.slice_done       (slice_done),
	.slice_total      (slice_total),
	.indicator_toggle (indicator_toggle),
	.last             (last)
);
